>>> rtl/pmp_pkg.sv
// ----------------------------------------------------------------------------
// pmp_pkg
// Shared types and constants for path marker placement.
// ----------------------------------------------------------------------------
`default_nettype none
package pmp_pkg;

  localparam int DiffW  = 33;
  // cordic working width: 33-bit magnitude plus gain headroom
  localparam int CordW  = 36;
  localparam int AccW   = 27;
  localparam int AngW   = 18;

  localparam logic [1:0] OP_MOVE  = 2'd0;
  localparam logic [1:0] OP_LINE  = 2'd1;
  localparam logic [1:0] OP_CUBIC = 2'd2;
  localparam logic [1:0] OP_CLOSE = 2'd3;

  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_MID   = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;

  localparam logic [1:0] REG_START_EN  = 2'd0;
  localparam logic [1:0] REG_MID_EN    = 2'd1;
  localparam logic [1:0] REG_END_EN    = 2'd2;
  localparam logic [1:0] REG_START_REV = 2'd3;

  localparam logic signed [AccW-1:0] Deg90  = AccW'(90 * 65536);
  localparam logic signed [AccW-1:0] Deg180 = AccW'(180 * 65536);

  // one cordic element moving down the chain
  typedef struct packed {
    logic                     vld;
    logic                     axis;
    logic signed [CordW-1:0]  x;
    logic signed [CordW-1:0]  y;
    logic signed [AccW-1:0]   acc;
  } cord_t;

  function automatic logic signed [AccW-1:0] atan_entry(input int i);
    logic signed [AccW-1:0] r;
    begin
      case (i)
        0: r = AccW'(2949120);  1: r = AccW'(1740967);  2: r = AccW'(919879);
        3: r = AccW'(466945);   4: r = AccW'(234379);   5: r = AccW'(117304);
        6: r = AccW'(58666);    7: r = AccW'(29335);    8: r = AccW'(14668);
        9: r = AccW'(7334);    10: r = AccW'(3667);    11: r = AccW'(1833);
        12: r = AccW'(917);    13: r = AccW'(458);     14: r = AccW'(229);
        15: r = AccW'(115);    16: r = AccW'(57);      17: r = AccW'(29);
        18: r = AccW'(14);     19: r = AccW'(7);       20: r = AccW'(4);
        21: r = AccW'(2);      22: r = AccW'(1);
        default: r = '0;
      endcase
      return r;
    end
  endfunction

endpackage
`default_nettype wire

>>> rtl/pmp_cell.sv
// ----------------------------------------------------------------------------
// pmp_cell
// One cordic vectoring step; registers the rotated vector for the next cell.
// ----------------------------------------------------------------------------
`default_nettype none
module pmp_cell #(
  parameter int Step = 0
) (
  input  wire             clk,
  input  wire             rst,
  input  pmp_pkg::cord_t  din,
  output pmp_pkg::cord_t  dout
);

  pmp_pkg::cord_t nxt;

  always_comb begin
    nxt = din;
    if (!din.axis) begin
      if (din.y > 0) begin
        nxt.x   = din.x + (din.y >>> Step);
        nxt.y   = din.y - (din.x >>> Step);
        nxt.acc = din.acc + pmp_pkg::atan_entry(Step);
      end else begin
        nxt.x   = din.x - (din.y >>> Step);
        nxt.y   = din.y + (din.x >>> Step);
        nxt.acc = din.acc - pmp_pkg::atan_entry(Step);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.vld <= 1'b0;
    end else begin
      dout.vld <= din.vld;
    end
    dout.axis <= nxt.axis;
    dout.x    <= nxt.x;
    dout.y    <= nxt.y;
    dout.acc  <= nxt.acc;
  end

endmodule
`default_nettype wire

>>> rtl/pmp_atan.sv
// ----------------------------------------------------------------------------
// pmp_atan
// atan2 in 2^-16 degree: prerotation cell and a chain of cordic cells.
// ----------------------------------------------------------------------------
`default_nettype none
module pmp_atan #(
  parameter int CordicSteps = 16
) (
  input  wire                                     clk,
  input  wire                                     rst,
  input  wire                                     start,
  input  wire signed [pmp_pkg::DiffW-1:0]         dx,
  input  wire signed [pmp_pkg::DiffW-1:0]         dy,
  output logic                                    done,
  output logic signed [pmp_pkg::AccW-1:0]         result
);

  pmp_pkg::cord_t chain [CordicSteps+1];
  pmp_pkg::cord_t pre;
  logic signed [pmp_pkg::CordW-1:0] ex, ey;

  always_comb begin
    ex = pmp_pkg::CordW'(dx);
    ey = pmp_pkg::CordW'(dy);
    pre.vld  = start;
    pre.axis = 1'b0;
    pre.x    = ex;
    pre.y    = ey;
    pre.acc  = '0;
    if (dy == '0) begin
      pre.axis = 1'b1;
      pre.acc  = (dx < 0) ? pmp_pkg::Deg180 : '0;
    end else if (dx == '0) begin
      pre.axis = 1'b1;
      pre.acc  = (dy > 0) ? pmp_pkg::Deg90 : -pmp_pkg::Deg90;
    end else if (dx < 0) begin
      if (dy > 0) begin
        pre.x = ey; pre.y = -ex; pre.acc = pmp_pkg::Deg90;
      end else begin
        pre.x = -ey; pre.y = ex; pre.acc = -pmp_pkg::Deg90;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chain[0].vld <= 1'b0;
    end else begin
      chain[0].vld <= pre.vld;
    end
    chain[0].axis <= pre.axis;
    chain[0].x    <= pre.x;
    chain[0].y    <= pre.y;
    chain[0].acc  <= pre.acc;
  end

  for (genvar i = 0; i < CordicSteps; i++) begin : g_cell
    pmp_cell #(.Step(i)) u_cell (
      .clk (clk),
      .rst (rst),
      .din (chain[i]),
      .dout(chain[i+1])
    );
  end

  always_comb begin
    done   = chain[CordicSteps].vld;
    result = chain[CordicSteps].acc;
    if (result > pmp_pkg::Deg180) result = pmp_pkg::Deg180;
    if (result < -pmp_pkg::Deg180) result = -pmp_pkg::Deg180;
  end

endmodule
`default_nettype wire

>>> rtl/path_marker_placement.sv
// ----------------------------------------------------------------------------
// path_marker_placement
// Places start, mid and end markers on path vertices with atan2 angles.
// ----------------------------------------------------------------------------
// channel   dir   handshake                   payload
// s_axis    in    s_axis_tvalid/tready        tdata, tuser=operation, tlast
// m_axis    out   m_axis_tvalid/tready        tdata, tuser=kind, tlast
// cfg       in    cfg_valid/cfg_ready         cfg_index, cfg_data
// an item runs the cordic chain up to three times (outgoing, incoming and end
// tangent); one item at a time, as s_axis_tready is high only in the idle state
// a result waiting in the output register stalls the next marker and the input
// rst is synchronous and clears path state and registers
`default_nettype none
module path_marker_placement #(
  parameter int CordicSteps = 16
) (
  input  wire          clk,
  input  wire          rst,
  input  wire          s_axis_tvalid,
  output logic         s_axis_tready,
  // p0_x, p0_y, p1_x, p1_y, p2_x, p2_y
  input  wire  [191:0] s_axis_tdata,
  // operation
  input  wire  [1:0]   s_axis_tuser,
  input  wire          s_axis_tlast,
  output logic         m_axis_tvalid,
  input  wire          m_axis_tready,
  // pos_x, pos_y, angle, zero fill
  output logic [87:0]  m_axis_tdata,
  // marker_kind
  output logic [1:0]   m_axis_tuser,
  output logic         m_axis_tlast,
  input  wire          cfg_valid,
  output logic         cfg_ready,
  input  wire  [1:0]   cfg_index,
  input  wire  [31:0]  cfg_data
);

  localparam int AccW = pmp_pkg::AccW;
  localparam int DW   = pmp_pkg::DiffW;
  localparam int AngW_loc = pmp_pkg::AngW;

  typedef enum logic [2:0] {
    ST_IDLE, ST_OUT, ST_IN, ST_EMIT1, ST_UPD, ST_END, ST_EMIT2
  } state_t;

  state_t state;
  logic start_en, mid_en, end_en, start_rev;
  logic signed [31:0] cur_x, cur_y, sub_x, sub_y, tf_x, tf_y, tt_x, tt_y;
  logic [1:0] items_seen;
  logic [1:0] op;
  logic signed [31:0] ax, ay, bx, by, cx, cy;
  logic last;
  logic signed [AccW-1:0] outang;

  logic cstart;
  logic signed [DW-1:0] cdx, cdy;
  logic cdone, cheld;
  logic signed [AccW-1:0] cres;

  logic signed [AccW-1:0] a_st, d;
  logic signed [AccW+1:0] msum;
  logic signed [AngW_loc-1:0] ang_st, ang_mid, ang_end;

  pmp_atan #(.CordicSteps(CordicSteps)) u_atan (
    .clk(clk), .rst(rst), .start(cstart), .dx(cdx), .dy(cdy),
    .done(cdone), .result(cres)
  );

  assign s_axis_tready = (state == ST_IDLE) && !cfg_valid;
  assign cfg_ready     = (state == ST_IDLE);

  always_comb begin
    logic signed [AccW:0] t;
    a_st = start_rev ? outang - pmp_pkg::Deg180 : outang;
    t = (AccW+1)'(a_st) + (AccW+1)'(128);
    ang_st = AngW_loc'(t >>> 8);
    d = cres - outang;
    if (d < 0) d = -d;
    msum = (AccW+2)'(cres) + (AccW+2)'(outang) + (AccW+2)'(256);
    if (d > pmp_pkg::Deg180) msum = msum + (AccW+2)'(2 * pmp_pkg::Deg180);
    ang_mid = AngW_loc'(msum >>> 9);
    t = (AccW+1)'(cres) + (AccW+1)'(128);
    ang_end = AngW_loc'(t >>> 8);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      start_en <= 1'b0; mid_en <= 1'b0; end_en <= 1'b0; start_rev <= 1'b0;
      cur_x <= '0; cur_y <= '0; sub_x <= '0; sub_y <= '0;
      tf_x <= '0; tf_y <= '0; tt_x <= '0; tt_y <= '0;
      items_seen <= '0;
      m_axis_tvalid <= 1'b0;
      cstart <= 1'b0;
      cheld <= 1'b0;
    end else begin
      if (cstart) cstart <= 1'b0;
      // cordic result stays valid while its operands are held
      if (cdone) cheld <= 1'b1;
      else if (cstart) cheld <= 1'b0;
      if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (cfg_valid) begin
            unique case (cfg_index)
              pmp_pkg::REG_START_EN:  start_en  <= cfg_data[0];
              pmp_pkg::REG_MID_EN:    mid_en    <= cfg_data[0];
              pmp_pkg::REG_END_EN:    end_en    <= cfg_data[0];
              pmp_pkg::REG_START_REV: start_rev <= cfg_data[0];
              default: ;
            endcase
          end else if (s_axis_tvalid) begin
            op <= s_axis_tuser;
            ax <= s_axis_tdata[31:0];    ay <= s_axis_tdata[63:32];
            bx <= s_axis_tdata[95:64];   by <= s_axis_tdata[127:96];
            cx <= s_axis_tdata[159:128]; cy <= s_axis_tdata[191:160];
            last <= s_axis_tlast;
            if (s_axis_tvalid && s_axis_tready && items_seen != 2'd0 &&
                ((items_seen == 2'd1 && start_en) || (items_seen == 2'd2 && mid_en))) begin
              cdx <= DW'(signed'(s_axis_tdata[31:0])) - DW'(cur_x);
              cdy <= DW'(signed'(s_axis_tdata[63:32])) - DW'(cur_y);
              cstart <= 1'b1;
              state <= ST_OUT;
            end else begin
              state <= ST_UPD;
            end
          end
        end
        ST_OUT: begin
          if (cdone) begin
            outang <= cres;
            if (items_seen == 2'd2) begin
              cdx <= DW'(tt_x) - DW'(tf_x);
              cdy <= DW'(tt_y) - DW'(tf_y);
              cstart <= 1'b1;
              state <= ST_IN;
            end else begin
              state <= ST_EMIT1;
            end
          end
        end
        ST_IN: begin
          if ((cdone || (cheld && !cstart)) && !m_axis_tvalid) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tuser <= pmp_pkg::KIND_MID;
            m_axis_tdata <= {6'd0, ang_mid, cur_y, cur_x};
            m_axis_tlast <= !(last && end_en);
            state <= ST_UPD;
          end
        end
        ST_EMIT1: begin
          if (!m_axis_tvalid) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tuser <= pmp_pkg::KIND_START;
            m_axis_tdata <= {6'd0, ang_st, cur_y, cur_x};
            m_axis_tlast <= !(last && end_en);
            state <= ST_UPD;
          end
        end
        ST_UPD: begin
          case (op)
            pmp_pkg::OP_MOVE: begin
              sub_x <= ax; sub_y <= ay;
              tf_x <= cur_x; tf_y <= cur_y; tt_x <= ax; tt_y <= ay;
              cur_x <= ax; cur_y <= ay;
            end
            pmp_pkg::OP_LINE: begin
              tf_x <= cur_x; tf_y <= cur_y; tt_x <= ax; tt_y <= ay;
              cur_x <= ax; cur_y <= ay;
            end
            pmp_pkg::OP_CUBIC: begin
              tf_x <= bx; tf_y <= by; tt_x <= cx; tt_y <= cy;
              cur_x <= cx; cur_y <= cy;
            end
            default: begin
              tf_x <= cur_x; tf_y <= cur_y; tt_x <= ax; tt_y <= ay;
              cur_x <= sub_x; cur_y <= sub_y;
              sub_x <= '0; sub_y <= '0;
            end
          endcase
          if (items_seen != 2'd2) items_seen <= items_seen + 2'd1;
          state <= (last && end_en) ? ST_END : (last ? ST_EMIT2 : ST_IDLE);
        end
        ST_END: begin
          cdx <= DW'(tt_x) - DW'(tf_x);
          cdy <= DW'(tt_y) - DW'(tf_y);
          cstart <= 1'b1;
          state <= ST_EMIT2;
        end
        ST_EMIT2: begin
          if (!end_en || !last) begin
            cur_x <= '0; cur_y <= '0; sub_x <= '0; sub_y <= '0;
            tf_x <= '0; tf_y <= '0; tt_x <= '0; tt_y <= '0;
            items_seen <= '0;
            state <= ST_IDLE;
          end else if ((cdone || (cheld && !cstart)) && !m_axis_tvalid) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tuser <= pmp_pkg::KIND_END;
            m_axis_tdata <= {6'd0, ang_end, cur_y, cur_x};
            m_axis_tlast <= 1'b1;
            cur_x <= '0; cur_y <= '0; sub_x <= '0; sub_y <= '0;
            tf_x <= '0; tf_y <= '0; tt_x <= '0; tt_y <= '0;
            items_seen <= '0;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_out_kind: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tuser != 2'd3) else $error("bad marker kind");
  a_idle_ready: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> !cstart) else $error("cordic start while idle");
  a_end_last: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser == pmp_pkg::KIND_END) |-> m_axis_tlast)
    else $error("end marker not last");
`endif

endmodule
`default_nettype wire

>>> tb/path_marker_placement_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// path_marker_placement_tb
// Drives path segments through the marker block under random flow control and
// compares every marker transaction with an in-bench angle and state predictor.
// ----------------------------------------------------------------------------
module path_marker_placement_tb;

  localparam int Steps = 16;
  localparam longint Deg = 65536;
  localparam int RandItems = 1150;
  localparam longint CycleLimit = 600000;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] px;
    logic [31:0] py;
    logic [17:0] ang;
    logic        fin;
  } marker_t;

  typedef struct {
    logic [1:0]  op;
    logic [31:0] pt [6];
    logic        last;
  } seg_t;

  logic clk = 0;
  logic rst = 1;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  logic [191:0] s_axis_tdata = '0;
  logic [1:0] s_axis_tuser = '0;
  logic s_axis_tlast = 0;
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  logic [87:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;
  logic m_axis_tlast;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  path_marker_placement #(.CordicSteps(Steps)) i_dut (.*);

  always #5 clk = ~clk;

  // predictor state
  logic en_start, en_mid, en_end, rev_start;
  longint cur_x, cur_y, sub_x, sub_y, tf_x, tf_y, tt_x, tt_y;
  int seen;
  marker_t marker_q [$];
  int errors = 0;
  longint cycles = 0;
  int send_idle = 8, recv_idle = 71;

  function automatic longint atan_deg(longint i);
    longint t [24] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
                       14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0};
    return t[i];
  endfunction

  function automatic longint heading(longint dx, longint dy);
    longint x, y, acc, nx;
    if (dy == 0) return dx >= 0 ? 0 : 180 * Deg;
    if (dx == 0) return dy > 0 ? 90 * Deg : -90 * Deg;
    if (dx < 0) begin
      if (dy > 0) begin
        x = dy; y = -dx; acc = 90 * Deg;
      end else begin
        x = -dy; y = dx; acc = -90 * Deg;
      end
    end else begin
      x = dx; y = dy; acc = 0;
    end
    for (int i = 0; i < Steps && i < 24; i++) begin
      if (y > 0) begin
        nx = x + (y >>> i); y = y - (x >>> i); acc += atan_deg(i);
      end else begin
        nx = x - (y >>> i); y = y + (x >>> i); acc -= atan_deg(i);
      end
      x = nx;
    end
    if (acc > 180 * Deg) acc = 180 * Deg;
    if (acc < -180 * Deg) acc = -180 * Deg;
    return acc;
  endfunction

  function automatic void clear_path();
    cur_x = 0; cur_y = 0; sub_x = 0; sub_y = 0;
    tf_x = 0; tf_y = 0; tt_x = 0; tt_y = 0; seen = 0;
  endfunction

  function automatic marker_t mk(logic [1:0] k, longint a);
    marker_t m;
    m.kind = k; m.px = cur_x[31:0]; m.py = cur_y[31:0]; m.ang = a[17:0]; m.fin = 0;
    return m;
  endfunction

  function automatic int place_markers(seg_t s);
    longint ax, ay, bx, by, cx, cy, outang, inang, a, d;
    marker_t res [$];
    ax = longint'(signed'(s.pt[0])); ay = longint'(signed'(s.pt[1]));
    bx = longint'(signed'(s.pt[2])); by = longint'(signed'(s.pt[3]));
    cx = longint'(signed'(s.pt[4])); cy = longint'(signed'(s.pt[5]));
    if (seen != 0) begin
      outang = heading(ax - cur_x, ay - cur_y);
      if (seen == 1 && en_start) begin
        a = outang;
        if (rev_start) a -= 180 * Deg;
        res.push_back(mk(pmp_pkg::KIND_START, (a + 128) >>> 8));
      end
      if (seen >= 2 && en_mid) begin
        inang = heading(tt_x - tf_x, tt_y - tf_y);
        d = inang - outang;
        if (d < 0) d = -d;
        if (d > 180 * Deg) inang += 360 * Deg;
        res.push_back(mk(pmp_pkg::KIND_MID, (inang + outang + 256) >>> 9));
      end
    end
    case (s.op)
      pmp_pkg::OP_MOVE: begin
        sub_x = ax; sub_y = ay; tf_x = cur_x; tf_y = cur_y;
        tt_x = ax; tt_y = ay; cur_x = ax; cur_y = ay;
      end
      pmp_pkg::OP_LINE: begin
        tf_x = cur_x; tf_y = cur_y; tt_x = ax; tt_y = ay; cur_x = ax; cur_y = ay;
      end
      pmp_pkg::OP_CUBIC: begin
        tf_x = bx; tf_y = by; tt_x = cx; tt_y = cy; cur_x = cx; cur_y = cy;
      end
      default: begin
        tf_x = cur_x; tf_y = cur_y; tt_x = ax; tt_y = ay;
        cur_x = sub_x; cur_y = sub_y; sub_x = 0; sub_y = 0;
      end
    endcase
    if (seen < 2) seen++;
    if (s.last) begin
      if (en_end)
        res.push_back(mk(pmp_pkg::KIND_END, (heading(tt_x - tf_x, tt_y - tf_y) + 128) >>> 8));
      clear_path();
    end
    if (res.size() > 0) res[res.size() - 1].fin = 1;
    foreach (res[i]) marker_q.push_back(res[i]);
    return res.size();
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout at %0t", $time);
      $display("status: fail");
      $finish;
    end
  end

  // output side
  always @(posedge clk) begin
    marker_t got, want;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tdata[81:64],
               m_axis_tlast};
        if (marker_q.size() == 0) begin
          $display("%0t unexpected transaction: expected none, actual %h", $time, got);
          errors++;
        end else begin
          want = marker_q.pop_front();
          if (got.kind != want.kind || got.px != want.px || got.py != want.py ||
              got.ang != want.ang || got.fin != want.fin) begin
            $display("%0t mismatch: expected %h, actual %h", $time, want, got);
            errors++;
          end
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  task automatic write_reg(logic [1:0] idx, logic v);
    cfg_index <= idx; cfg_data <= {31'b0, v}; cfg_valid <= 1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      pmp_pkg::REG_START_EN: en_start = v;
      pmp_pkg::REG_MID_EN: en_mid = v;
      pmp_pkg::REG_END_EN: en_end = v;
      default: rev_start = v;
    endcase
  endtask

  task automatic set_regs(logic [3:0] v);
    s_axis_tvalid <= 0;
    while (marker_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    write_reg(pmp_pkg::REG_START_EN, v[0]);
    write_reg(pmp_pkg::REG_MID_EN, v[1]);
    write_reg(pmp_pkg::REG_END_EN, v[2]);
    write_reg(pmp_pkg::REG_START_REV, v[3]);
    cfg_valid <= 0;
  endtask

  task automatic send_seg(seg_t s);
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tuser <= s.op;
    s_axis_tlast <= s.last;
    s_axis_tdata <= {s.pt[5], s.pt[4], s.pt[3], s.pt[2], s.pt[1], s.pt[0]};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    void'(place_markers(s));
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(5))
      0: return $urandom();
      1: return {$urandom_range(1) ? 1'b1 : 1'b0, 31'(0)} ^ ($urandom_range(1) ? '1 : '0);
      2: return 32'($signed($urandom_range(16)) - 8) << 16;
      default: return 32'($signed(int'($urandom_range(2000000))) - 1000000);
    endcase
  endfunction

  function automatic seg_t rand_seg(int pos, int len);
    seg_t s;
    s.op = (pos == 0 && $urandom_range(9) != 0) ? pmp_pkg::OP_MOVE : 2'($urandom_range(3));
    foreach (s.pt[i]) s.pt[i] = rand_coord();
    if ($urandom_range(7) == 0) s.pt[1] = s.pt[0] ^ s.pt[1] ^ s.pt[0];
    s.last = (pos == len - 1);
    return s;
  endfunction

  seg_t dir_tab [$];

  function automatic seg_t mkseg(logic [1:0] op, logic [31:0] x, logic [31:0] y,
                                 logic [31:0] x1, logic [31:0] y1, logic [31:0] x2,
                                 logic [31:0] y2, logic l);
    seg_t s;
    s.op = op; s.pt = '{x, y, x1, y1, x2, y2}; s.last = l;
    return s;
  endfunction

  initial begin
    int len;
    clear_path();
    en_start = 0; en_mid = 0; en_end = 0; rev_start = 0;
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // registers at reset: no markers expected
    dir_tab.push_back(mkseg(pmp_pkg::OP_MOVE, 32'h10000, 0, 0, 0, 0, 0, 0));
    dir_tab.push_back(mkseg(pmp_pkg::OP_LINE, 32'h20000, 0, 0, 0, 0, 0, 1));
    foreach (dir_tab[i]) send_seg(dir_tab[i]);
    dir_tab.delete();
    set_regs(4'b1111);
    // axes, zero vector, extremes, every operation, close without move
    dir_tab.push_back(mkseg(pmp_pkg::OP_MOVE, 0, 0, 0, 0, 0, 0, 0));
    dir_tab.push_back(mkseg(pmp_pkg::OP_LINE, 32'h7fffffff, 0, 0, 0, 0, 0, 0));
    dir_tab.push_back(mkseg(pmp_pkg::OP_LINE, 32'h80000000, 0, 0, 0, 0, 0, 0));
    dir_tab.push_back(mkseg(pmp_pkg::OP_LINE, 32'h80000000, 32'h7fffffff, 0, 0, 0, 0, 0));
    dir_tab.push_back(mkseg(pmp_pkg::OP_LINE, 32'h80000000, 32'h80000000, 0, 0, 0, 0, 0));
    dir_tab.push_back(mkseg(pmp_pkg::OP_CUBIC, 32'h7fffffff, 32'h7fffffff, 32'h80000000,
                            32'h7fffffff, 32'h7fffffff, 32'h80000000, 0));
    dir_tab.push_back(mkseg(pmp_pkg::OP_LINE, 32'h7fffffff, 32'h80000000, 0, 0, 0, 0, 0));
    dir_tab.push_back(mkseg(pmp_pkg::OP_LINE, 32'hffff0000, 32'h00010000, 0, 0, 0, 0, 0));
    dir_tab.push_back(mkseg(pmp_pkg::OP_CLOSE, 0, 0, 0, 0, 0, 0, 1));
    dir_tab.push_back(mkseg(pmp_pkg::OP_CLOSE, 32'h30000, 32'hfffd0000, 0, 0, 0, 0, 0));
    dir_tab.push_back(mkseg(pmp_pkg::OP_LINE, 32'hfffd0000, 32'h30000, 0, 0, 0, 0, 0));
    dir_tab.push_back(mkseg(pmp_pkg::OP_LINE, 32'hfffe0000, 32'hfffd0000, 0, 0, 0, 0, 1));
    dir_tab.push_back(mkseg(pmp_pkg::OP_MOVE, 32'h50000, 32'h50000, 0, 0, 0, 0, 1));
    foreach (dir_tab[i]) send_seg(dir_tab[i]);
    set_regs(4'b0111);
    foreach (dir_tab[i]) send_seg(dir_tab[i]);
    for (int ph = 0; ph < 3; ph++) begin
      if (ph == 1) begin
        send_idle = 71; recv_idle = 8;
      end else if (ph == 2) begin
        send_idle = 0; recv_idle = 0;
      end
      for (int k = 0; k < RandItems / 3;) begin
        if ($urandom_range(5) == 0) set_regs(4'($urandom()));
        len = $urandom_range(1, 8);
        for (int p = 0; p < len; p++) send_seg(rand_seg(p, len));
        k += len;
      end
    end
    set_regs(4'b0000);
    while (marker_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0 && marker_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

>>> path_marker_placement.f
rtl/pmp_pkg.sv
rtl/pmp_cell.sv
rtl/pmp_atan.sv
rtl/path_marker_placement.sv
tb/path_marker_placement_tb.sv
